@@ design/sp2c_pkg.sv @@
// Shared constants, types and the arctangent table for the scan projection block.
`timescale 1ns / 1ps
package sp2c_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int RANGE_BITS    = 16;
  localparam int FRAC_BITS     = 16;
  localparam int ATAN_LEN      = 24;
  localparam int NSTAGE        = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int XW            = RANGE_BITS + FRAC_BITS + 2;
  localparam int ZW            = 32;
  localparam int GAIN_BITS     = 30;
  localparam logic [GAIN_BITS-1:0] GAIN_Q30 = 30'd652032874;
  localparam int OUT_MAX       = 65535;
  localparam int QDEPTH        = 4;
  localparam int QAW           = $clog2(QDEPTH);
  localparam logic [15:0] CUTOFF_RESET = 16'd30000;

  typedef enum logic [1:0] {
    REG_ANGLE_START = 2'd0,
    REG_ANGLE_STEP  = 2'd1,
    REG_RANGE_MIN   = 2'd2,
    REG_RANGE_LIMIT = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [XW-1:0] x0;
    logic signed [ZW-1:0] z;
    logic [1:0]           quad;
    logic                 kept;
    logic                 last;
  } item_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           quad;
    logic                 kept;
    logic                 last;
  } stage_t;

  function automatic logic signed [ZW-1:0] atan_of(input int unsigned i);
    logic signed [ZW-1:0] a;
    unique case (i)
      0:  a = 32'sd536870912;
      1:  a = 32'sd316933406;
      2:  a = 32'sd167458907;
      3:  a = 32'sd85004756;
      4:  a = 32'sd42667331;
      5:  a = 32'sd21354465;
      6:  a = 32'sd10679838;
      7:  a = 32'sd5340245;
      8:  a = 32'sd2670163;
      9:  a = 32'sd1335087;
      10: a = 32'sd667544;
      11: a = 32'sd333772;
      12: a = 32'sd166886;
      13: a = 32'sd83443;
      14: a = 32'sd41722;
      15: a = 32'sd20861;
      16: a = 32'sd10430;
      17: a = 32'sd5215;
      18: a = 32'sd2608;
      19: a = 32'sd1304;
      20: a = 32'sd652;
      21: a = 32'sd326;
      22: a = 32'sd163;
      23: a = 32'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ design/sp2c_front.sv @@
// Front end: configuration registers, beam counter, angle reduction, gain scaling, keep test.
`timescale 1ns / 1ps
module sp2c_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         range_mm,
  input  logic                scan_end,
  output logic                push_valid,
  input  logic                push_ready,
  output sp2c_pkg::item_t     push_item
);

  logic [15:0] angle_start;
  logic [15:0] angle_step;
  logic [15:0] range_minimum;
  logic [15:0] range_limit;
  logic [15:0] beam_index;

  logic [31:0] step_prod;
  logic [15:0] angle;
  logic [15:0] quad_sum;
  logic [1:0]  quad;
  logic [15:0] resid;
  logic [sp2c_pkg::RANGE_BITS-1:0] r;
  logic [sp2c_pkg::RANGE_BITS+sp2c_pkg::GAIN_BITS-1:0] gain_prod;
  logic accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_start   <= '0;
      angle_step    <= '0;
      range_minimum <= '0;
      range_limit   <= sp2c_pkg::CUTOFF_RESET;
    end else if (cfg_we) begin
      unique case (sp2c_pkg::reg_index_t'(cfg_index))
        sp2c_pkg::REG_ANGLE_START: angle_start   <= cfg_data;
        sp2c_pkg::REG_ANGLE_STEP:  angle_step    <= cfg_data;
        sp2c_pkg::REG_RANGE_MIN:   range_minimum <= cfg_data;
        sp2c_pkg::REG_RANGE_LIMIT: range_limit   <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_index <= '0;
    end else if (accept) begin
      beam_index <= scan_end ? 16'd0 : beam_index + 16'd1;
    end
  end

  always_comb begin
    step_prod = 32'(beam_index) * 32'(angle_step);
    angle     = angle_start + step_prod[15:0];
    quad_sum  = angle + 16'd8192;
    quad      = quad_sum[15:14];
    resid     = angle - {quad, 14'd0};
    r         = sp2c_pkg::RANGE_BITS'(range_mm);
    gain_prod = (sp2c_pkg::RANGE_BITS + sp2c_pkg::GAIN_BITS)'(r) *
                (sp2c_pkg::RANGE_BITS + sp2c_pkg::GAIN_BITS)'(sp2c_pkg::GAIN_Q30);

    push_item.x0   = $signed({2'b00, gain_prod[sp2c_pkg::RANGE_BITS+sp2c_pkg::GAIN_BITS-1:
                                               sp2c_pkg::GAIN_BITS-sp2c_pkg::FRAC_BITS]});
    push_item.z    = $signed({resid, 16'd0});
    push_item.quad = quad;
    push_item.kept = (32'(r) >= 32'(range_minimum)) && (32'(r) < 32'(range_limit));
    push_item.last = scan_end;
  end

endmodule

@@ design/sp2c_queue.sv @@
// Short queue between the front end and the rotation pipeline.
`timescale 1ns / 1ps
module sp2c_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  sp2c_pkg::item_t  push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output sp2c_pkg::item_t  pop_item
);

  sp2c_pkg::item_t mem [sp2c_pkg::QDEPTH];
  logic [sp2c_pkg::QAW-1:0] wr_ptr;
  logic [sp2c_pkg::QAW-1:0] rd_ptr;
  logic [sp2c_pkg::QAW:0]   count;
  logic push;
  logic pop;

  assign push_ready = count != (sp2c_pkg::QAW + 1)'(sp2c_pkg::QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

@@ design/sp2c_back.sv @@
// Back end: pipelined rotation, quadrant mapping, rounding and saturation, output register.
`timescale 1ns / 1ps
module sp2c_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  sp2c_pkg::item_t    pop_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] x_mm,
  output logic signed [16:0] y_mm,
  output logic               kept,
  output logic               last_out
);

  sp2c_pkg::stage_t stg [sp2c_pkg::NSTAGE+1];
  sp2c_pkg::stage_t nxt [sp2c_pkg::NSTAGE];
  logic             vld [sp2c_pkg::NSTAGE+1];
  sp2c_pkg::stage_t load;
  logic signed [sp2c_pkg::XW-1:0] xr;
  logic signed [sp2c_pkg::XW-1:0] yr;
  logic adv;

  function automatic logic [16:0] to_mm(input logic signed [sp2c_pkg::XW-1:0] v);
    logic [sp2c_pkg::XW:0] sum;
    logic signed [sp2c_pkg::XW-sp2c_pkg::FRAC_BITS:0] rnd;
    logic signed [31:0] w;
    sum = {v[sp2c_pkg::XW-1], v} + (sp2c_pkg::XW + 1)'(1 << (sp2c_pkg::FRAC_BITS - 1));
    rnd = $signed(sum[sp2c_pkg::XW:sp2c_pkg::FRAC_BITS]);
    w   = 32'(rnd);
    if (w > 32'sd65535) begin
      w = 32'sd65535;
    end else if (w < -32'sd65535) begin
      w = -32'sd65535;
    end
    return w[16:0];
  endfunction

  assign adv       = !out_valid || out_ready;
  assign pop_ready = adv;

  always_comb begin
    load.x    = pop_item.x0;
    load.y    = '0;
    load.z    = pop_item.z;
    load.quad = pop_item.quad;
    load.kept = pop_item.kept;
    load.last = pop_item.last;
  end

  for (genvar g = 0; g < sp2c_pkg::NSTAGE; g++) begin : g_stage
    logic signed [sp2c_pkg::XW-1:0] xs;
    logic signed [sp2c_pkg::XW-1:0] ys;
    assign xs = $signed(stg[g].x) >>> g;
    assign ys = $signed(stg[g].y) >>> g;
    always_comb begin
      nxt[g] = stg[g];
      if (!stg[g].z[sp2c_pkg::ZW-1]) begin
        nxt[g].x = $signed(stg[g].x) - ys;
        nxt[g].y = $signed(stg[g].y) + xs;
        nxt[g].z = $signed(stg[g].z) - sp2c_pkg::atan_of(g);
      end else begin
        nxt[g].x = $signed(stg[g].x) + ys;
        nxt[g].y = $signed(stg[g].y) - xs;
        nxt[g].z = $signed(stg[g].z) + sp2c_pkg::atan_of(g);
      end
    end
  end

  always_comb begin
    unique case (stg[sp2c_pkg::NSTAGE].quad)
      2'd0: begin
        xr = stg[sp2c_pkg::NSTAGE].x;
        yr = stg[sp2c_pkg::NSTAGE].y;
      end
      2'd1: begin
        xr = -$signed(stg[sp2c_pkg::NSTAGE].y);
        yr = stg[sp2c_pkg::NSTAGE].x;
      end
      2'd2: begin
        xr = -$signed(stg[sp2c_pkg::NSTAGE].x);
        yr = -$signed(stg[sp2c_pkg::NSTAGE].y);
      end
      default: begin
        xr = stg[sp2c_pkg::NSTAGE].y;
        yr = -$signed(stg[sp2c_pkg::NSTAGE].x);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= sp2c_pkg::NSTAGE; i++) vld[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld[0] <= pop_valid;
      for (int i = 0; i < sp2c_pkg::NSTAGE; i++) vld[i+1] <= vld[i];
      out_valid <= vld[sp2c_pkg::NSTAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0] <= load;
      for (int i = 0; i < sp2c_pkg::NSTAGE; i++) stg[i+1] <= nxt[i];
      x_mm     <= $signed(to_mm(xr));
      y_mm     <= $signed(to_mm(yr));
      kept     <= stg[sp2c_pkg::NSTAGE].kept;
      last_out <= stg[sp2c_pkg::NSTAGE].last;
    end
  end

endmodule

@@ design/scan_polar_to_cartesian_top.sv @@
// Top level of the laser scan polar-to-cartesian projection block.
// Path: an input beat is written into the queue, then registered in the load stage, in each
// CORDIC stage and in the output register. Throughput: one beat per cycle while the output
// is not held back; the rotation pipeline advances whenever the output register is empty or
// being taken, and a four-entry queue absorbs front-end beats meanwhile.
// Reset: synchronous; clears registers to defaults (cutoff 30000), beam index, queue, pipeline.
`timescale 1ns / 1ps
module scan_polar_to_cartesian_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        range_mm,
  input  logic               scan_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] x_mm,
  output logic signed [16:0] y_mm,
  output logic               kept,
  output logic               last_out
);

  logic            push_valid;
  logic            push_ready;
  sp2c_pkg::item_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  sp2c_pkg::item_t pop_item;

  sp2c_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .range_mm   (range_mm),
    .scan_end   (scan_end),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  sp2c_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  sp2c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .x_mm      (x_mm),
    .y_mm      (y_mm),
    .kept      (kept),
    .last_out  (last_out)
  );

  a_reset_clears: assert property (@(posedge clk) rst |=> in_ready && !out_valid && !pop_valid)
    else $error("reset did not empty the queue and output");

  a_full_has_head: assert property (@(posedge clk) disable iff (rst) !in_ready |-> pop_valid)
    else $error("input stalled while queue empty");

  a_head_held: assert property (@(posedge clk) disable iff (rst)
    pop_valid && !pop_ready |=> pop_valid && $stable(pop_item))
    else $error("queue head changed while pipeline stalled");

  a_stall_follows_output: assert property (@(posedge clk) disable iff (rst)
    !pop_ready |-> out_valid && !out_ready)
    else $error("pipeline stalled without output back-pressure");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the scan polar-to-cartesian projection block.
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = sp2c_pkg::CORDIC_STAGES + 4;
  localparam int BLOCK_BEATS = 88;

  typedef struct packed {
    logic signed [16:0] x_mm;
    logic signed [16:0] y_mm;
    logic               kept;
    logic               last;
  } point_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = sp2c_pkg::REG_ANGLE_START;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        range_mm = '0;
  logic               scan_end = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [16:0] x_mm;
  logic signed [16:0] y_mm;
  logic               kept;
  logic               last_out;

  longint arctan_turn32 [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic [15:0] ang_start = '0;
  logic [15:0] ang_step = '0;
  logic [15:0] min_mm = '0;
  logic [15:0] cutoff_mm = sp2c_pkg::CUTOFF_RESET;
  logic [15:0] beam_count = '0;

  point_t      pending_points [$];
  point_t      seen_point;
  point_t      due_point;
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned cycle_count = 0;

  scan_polar_to_cartesian_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .range_mm  (range_mm),
    .scan_end  (scan_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .x_mm      (x_mm),
    .y_mm      (y_mm),
    .kept      (kept),
    .last_out  (last_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("scan_polar_to_cartesian_top test failed");
    $finish;
  end

  function automatic logic signed [16:0] round_to_mm(input longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > sp2c_pkg::OUT_MAX) r = sp2c_pkg::OUT_MAX;
    if (r < -sp2c_pkg::OUT_MAX) r = -sp2c_pkg::OUT_MAX;
    return r[16:0];
  endfunction

  // rotate one beam and advance the beam counter
  function automatic point_t project_beam(input logic [15:0] rng, input logic last);
    logic [15:0] ang;
    logic [16:0] biased;
    logic [1:0]  quad;
    logic [15:0] resid;
    longint      r, x, y, z, xs, ys, xr, yr;
    int          n_stages;
    point_t      p;
    n_stages = (sp2c_pkg::CORDIC_STAGES > 24) ? 24 : sp2c_pkg::CORDIC_STAGES;
    r = longint'(rng) & ((longint'(1) << sp2c_pkg::RANGE_BITS) - 1);
    ang = ang_start + beam_count * ang_step;
    biased = {1'b0, ang} + 17'd8192;
    quad = biased[15:14];
    resid = ang - {quad, 14'd0};
    z = longint'($signed(resid)) * 65536;
    x = (r * 64'sd652032874) >>> 14;
    y = 0;
    for (int i = 0; i < n_stages; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_turn32[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_turn32[i];
      end
    end
    case (quad)
      2'd0: begin xr = x;  yr = y;  end
      2'd1: begin xr = -y; yr = x;  end
      2'd2: begin xr = -x; yr = -y; end
      default: begin xr = y; yr = -x; end
    endcase
    p.x_mm = round_to_mm(xr);
    p.y_mm = round_to_mm(yr);
    p.kept = (r >= longint'(min_mm)) && (r < longint'(cutoff_mm));
    p.last = last;
    beam_count = last ? 16'd0 : beam_count + 16'd1;
    return p;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_point = '{x_mm, y_mm, kept, last_out};
      if (pending_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected beat: x=%0d y=%0d kept=%0b last=%0b",
                   x_mm, y_mm, kept, last_out);
      end else begin
        due_point = pending_points.pop_front();
        if (seen_point !== due_point) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp x=%0d y=%0d k=%0b l=%0b got x=%0d y=%0d k=%0b l=%0b",
                     due_point.x_mm, due_point.y_mm, due_point.kept, due_point.last,
                     x_mm, y_mm, kept, last_out);
        end
      end
    end
    out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  task automatic send_beam(input logic [15:0] rng, input logic last);
    point_t p;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    range_mm <= rng;
    scan_end <= last;
    do @(posedge clk); while (!in_ready);
    p = project_beam(rng, last);
    pending_points.insert(pending_points.size(), p);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input sp2c_pkg::reg_index_t idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic program_scan(input logic [15:0] start, input logic [15:0] step,
                              input logic [15:0] low, input logic [15:0] cut);
    write_reg(sp2c_pkg::REG_ANGLE_START, start);
    write_reg(sp2c_pkg::REG_ANGLE_STEP, step);
    write_reg(sp2c_pkg::REG_RANGE_MIN, low);
    write_reg(sp2c_pkg::REG_RANGE_LIMIT, cut);
    cfg_we <= 1'b0;
    ang_start = start;
    ang_step = step;
    min_mm = low;
    cutoff_mm = cut;
  endtask

  function automatic logic [15:0] pick_range();
    case ($urandom_range(9, 0))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return min_mm + 16'($urandom_range(2, 0)) - 16'd1;
      3: return cutoff_mm + 16'($urandom_range(2, 0)) - 16'd1;
      default: return 16'($urandom_range(65535, 0));
    endcase
  endfunction

  task automatic test_defaults();
    send_beam(16'd0, 1'b0);
    send_beam(16'd1, 1'b0);
    send_beam(16'd29999, 1'b0);
    send_beam(16'd30000, 1'b0);
    send_beam(16'hFFFF, 1'b0);
    send_beam(16'd12345, 1'b1);
    wait_drained();
  endtask

  task automatic test_quadrants();
    program_scan(16'd0, 16'd8192, 16'd1000, 16'hFFFF);
    for (int k = 0; k < 5; k++) send_beam(16'hFFFF, 1'b0);
    send_beam(16'd1000, 1'b0);
    send_beam(16'd999, 1'b0);
    send_beam(16'hFFFE, 1'b0);
    send_beam(16'd0, 1'b1);
    wait_drained();
    program_scan(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    send_beam(16'hFFFF, 1'b0);
    send_beam(16'd0, 1'b0);
    send_beam(16'd32768, 1'b1);
    send_beam(16'h5555, 1'b0);
    send_beam(16'hAAAA, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    logic [15:0] step, low, cut;
    int          sent, len;
    bit          broken;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int blk = 0; blk < 3; blk++) begin
      wait_drained();
      case ($urandom_range(3, 0))
        0: step = 16'd0;
        1: step = 16'hFFFF;
        2: step = 16'(65536 / $urandom_range(40, 1));
        default: step = 16'($urandom_range(65535, 0));
      endcase
      case ($urandom_range(3, 0))
        0: low = 16'd0;
        1: low = 16'($urandom_range(65535, 0));
        default: low = 16'($urandom_range(3000, 0));
      endcase
      case ($urandom_range(4, 0))
        0: cut = sp2c_pkg::CUTOFF_RESET;
        1: cut = 16'hFFFF;
        2: cut = 16'd0;
        default: cut = 16'($urandom_range(65535, 0));
      endcase
      program_scan(16'($urandom_range(65535, 0)), step, low, cut);
      sent = 0;
      while (sent < BLOCK_BEATS) begin
        len = $urandom_range(40, 1);
        broken = ($urandom_range(9, 0) == 0);
        for (int k = 0; k < len; k++) begin
          send_beam(pick_range(), broken ? 1'($urandom_range(1, 0)) : (k == len - 1));
          sent++;
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_quadrants();
    test_random_traffic(22, 84);
    test_random_traffic(84, 22);
    test_random_traffic(0, 0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("scan_polar_to_cartesian_top test passed");
    end else begin
      $display("scan_polar_to_cartesian_top test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/sp2c_pkg.sv
design/sp2c_front.sv
design/sp2c_queue.sv
design/sp2c_back.sv
design/scan_polar_to_cartesian_top.sv
tb/sv/testbench.sv
